>>> hw/rtl/swr_pkg.sv
`default_nettype none

package swr_pkg;

    localparam int COLUMNS = 320;
    localparam int ROWS    = 240;

    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int SUM_W  = COL_W + 1;
    localparam int DATA_W = 8;
    localparam int COLOR_W = 16;
    localparam int RAW_W  = 16;

    localparam int CMD_DEPTH = 4;
    localparam int CMD_AW    = $clog2(CMD_DEPTH);
    localparam int CMD_CW    = $clog2(CMD_DEPTH + 1);
    localparam int RES_DEPTH = 4;
    localparam int RES_AW    = $clog2(RES_DEPTH);
    localparam int RES_CW    = $clog2(RES_DEPTH + 1);

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_B    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_FILL = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_B   = 2'd3;

    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_PIXEL  = 1'b1;

    localparam logic [COLOR_W-1:0] RST_COLOR_A    = 16'hF800;
    localparam logic [COLOR_W-1:0] RST_COLOR_B    = 16'h07E0;
    localparam logic [COLOR_W-1:0] RST_COLOR_FILL = 16'h0000;
    localparam logic [DATA_W-1:0]  RST_OFFSET_B   = 8'd120;
    localparam logic [DATA_W-1:0]  RST_ROW_A      = 8'd60;
    localparam logic [DATA_W-1:0]  RST_ROW_B      = 8'd180;

    localparam logic [11:0]       RAW_SPAN = 12'd4095;
    localparam logic [6:0]        ROW_SPAN = 7'd100;
    localparam logic [DATA_W-1:0] ROW_BASE = 8'd10;

    typedef struct packed {
        logic              func;
        logic [DATA_W-1:0] row_a;
        logic [DATA_W-1:0] row_b;
    } t_cmd;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic               first;
        logic               last;
    } t_res;

endpackage

`default_nettype wire

>>> hw/rtl/swr_ram.sv
`default_nettype none

module swr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 320
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> hw/rtl/swr_front.sv
`default_nettype none

module swr_front
    import swr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic              i_func,
    input  wire logic [RAW_W-1:0]  i_sample_a,
    input  wire logic [RAW_W-1:0]  i_sample_b,
    input  wire logic [DATA_W-1:0] i_offset_b,
    output logic                   o_full,
    output logic                   o_cmd_valid,
    output t_cmd                   o_cmd,
    input  wire logic              i_cmd_pop
);

    // clamp to the converter window, then row = x*100/4095 + 10
    function automatic logic [DATA_W-1:0] scale_row(input logic [RAW_W-1:0] raw);
        logic [11:0] x;
        logic [18:0] p;
        logic [6:0]  q0;
        logic [12:0] rem;
        logic [6:0]  q;
        if (!raw[15]) begin
            x = '0;
        end else if (raw[14:12] != 3'b000) begin
            x = RAW_SPAN;
        end else begin
            x = raw[11:0];
        end
        p   = 19'(x) * 19'(ROW_SPAN);
        q0  = p[18:12];
        rem = 13'(p[11:0]) + 13'(q0);
        q   = (rem >= 13'(RAW_SPAN)) ? q0 + 7'd1 : q0;
        return DATA_W'(q) + ROW_BASE;
    endfunction

    logic [DATA_W-1:0] w_row_a;
    logic [DATA_W:0]   w_sum_b;
    t_cmd              w_entry;
    logic              w_push_ok;

    t_cmd              r_q [CMD_DEPTH];
    logic [CMD_AW-1:0] r_wr, r_rd;
    logic [CMD_CW-1:0] r_cnt;
    logic [CMD_CW-1:0] n_cnt;

    assign w_row_a = scale_row(i_sample_a);
    assign w_sum_b = (DATA_W+1)'(scale_row(i_sample_b)) + (DATA_W+1)'(i_offset_b);

    always_comb begin
        w_entry.func  = i_func;
        w_entry.row_a = w_row_a;
        w_entry.row_b = w_sum_b[DATA_W] ? '1 : w_sum_b[DATA_W-1:0];
    end

    assign o_full      = (r_cnt == CMD_CW'(CMD_DEPTH));
    assign w_push_ok   = i_push && !o_full;
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (w_push_ok && !(i_cmd_pop && o_cmd_valid)) begin
            n_cnt = r_cnt + CMD_CW'(1);
        end else if (!w_push_ok && i_cmd_pop && o_cmd_valid) begin
            n_cnt = r_cnt - CMD_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_q[r_wr] <= w_entry;
        end
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push_ok) begin
                r_wr <= r_wr + CMD_AW'(1);
            end
            if (i_cmd_pop && o_cmd_valid) begin
                r_rd <= r_rd + CMD_AW'(1);
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/swr_back.sv
`default_nettype none

module swr_back
    import swr_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cmd_valid,
    input  wire t_cmd               i_cmd,
    output logic                    o_cmd_pop,
    input  wire logic [COLOR_W-1:0] i_color_a,
    input  wire logic [COLOR_W-1:0] i_color_b,
    input  wire logic [COLOR_W-1:0] i_color_fill,
    output logic                    o_empty,
    input  wire logic               i_pop,
    output t_res                    o_res
);

    function automatic logic on_seg(input logic [DATA_W-1:0] row,
                                    input logic [DATA_W-1:0] l,
                                    input logic [DATA_W-1:0] r);
        logic [DATA_W-1:0] lo, hi;
        lo = (l < r) ? l : r;
        hi = (l < r) ? r : l;
        return (row >= lo) && (row <= hi);
    endfunction

    logic [COL_W-1:0] r_wp, r_col;
    logic [ROW_W-1:0] r_row;
    logic             r_wrapped;

    logic [SUM_W-1:0] w_sum;
    logic [COL_W-1:0] w_cur, w_prev;
    logic             w_can_pix, w_issue, w_is_pix, w_is_smp;

    logic [2*DATA_W-1:0] w_rd_cur, w_rd_prev;

    logic              r_s1_valid;
    logic [DATA_W-1:0] r_s1_row;
    logic              r_s1_first, r_s1_last, r_s1_cur_ok, r_s1_prev_ok;

    logic [DATA_W-1:0] w_a_cur, w_a_prev, w_b_cur, w_b_prev;
    t_res              w_res;

    t_res              r_res_q [RES_DEPTH];
    logic [RES_AW-1:0] r_res_wr, r_res_rd;
    logic [RES_CW-1:0] r_res_cnt;
    logic              w_res_pop;

    // ring position of this column: oldest sample at the left edge
    assign w_sum  = SUM_W'(r_wp) + SUM_W'(r_col);
    assign w_cur  = (w_sum >= SUM_W'(COLUMNS)) ? COL_W'(w_sum - SUM_W'(COLUMNS))
                                               : COL_W'(w_sum);
    assign w_prev = (w_cur == '0) ? COL_W'(COLUMNS - 1) : w_cur - COL_W'(1);

    // credit: a pixel issues only if the result queue can still take it
    assign w_can_pix = (RES_CW'(r_res_cnt) + RES_CW'(r_s1_valid)) < RES_CW'(RES_DEPTH);
    assign w_issue   = i_cmd_valid && ((i_cmd.func == FUNC_SAMPLE) || w_can_pix);
    assign w_is_pix  = w_issue && (i_cmd.func == FUNC_PIXEL);
    assign w_is_smp  = w_issue && (i_cmd.func == FUNC_SAMPLE);
    assign o_cmd_pop = w_issue;

    swr_ram #(.WIDTH(2*DATA_W), .DEPTH(COLUMNS)) u_ram_cur (
        .i_clk   (i_clk),
        .i_we    (w_is_smp),
        .i_waddr (r_wp),
        .i_wdata ({i_cmd.row_b, i_cmd.row_a}),
        .i_raddr (w_cur),
        .o_rdata (w_rd_cur)
    );

    swr_ram #(.WIDTH(2*DATA_W), .DEPTH(COLUMNS)) u_ram_prev (
        .i_clk   (i_clk),
        .i_we    (w_is_smp),
        .i_waddr (r_wp),
        .i_wdata ({i_cmd.row_b, i_cmd.row_a}),
        .i_raddr (w_prev),
        .o_rdata (w_rd_prev)
    );

    always_ff @(posedge i_clk) begin
        r_s1_row     <= DATA_W'(r_row);
        r_s1_first   <= (r_col == '0) && (r_row == '0);
        r_s1_last    <= (r_col == COL_W'(COLUMNS - 1)) && (r_row == ROW_W'(ROWS - 1));
        r_s1_cur_ok  <= r_wrapped || (w_cur < r_wp);
        r_s1_prev_ok <= r_wrapped || (w_prev < r_wp);
        if (!i_rst_n) begin
            r_wp       <= '0;
            r_wrapped  <= 1'b0;
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_is_pix;
            if (w_is_smp) begin
                if (r_wp == COL_W'(COLUMNS - 1)) begin
                    r_wp      <= '0;
                    r_wrapped <= 1'b1;
                end else begin
                    r_wp <= r_wp + COL_W'(1);
                end
            end
            if (w_is_pix) begin
                if (r_row == ROW_W'(ROWS - 1)) begin
                    r_row <= '0;
                    r_col <= (r_col == COL_W'(COLUMNS - 1)) ? '0 : r_col + COL_W'(1);
                end else begin
                    r_row <= r_row + ROW_W'(1);
                end
            end
        end
    end

    // never-written entries read as the power-up trace
    assign w_a_cur  = r_s1_cur_ok  ? w_rd_cur[DATA_W-1:0]          : RST_ROW_A;
    assign w_b_cur  = r_s1_cur_ok  ? w_rd_cur[2*DATA_W-1:DATA_W]   : RST_ROW_B;
    assign w_a_prev = r_s1_prev_ok ? w_rd_prev[DATA_W-1:0]         : RST_ROW_A;
    assign w_b_prev = r_s1_prev_ok ? w_rd_prev[2*DATA_W-1:DATA_W]  : RST_ROW_B;

    always_comb begin
        w_res.first = r_s1_first;
        w_res.last  = r_s1_last;
        priority if (on_seg(r_s1_row, w_a_prev, w_a_cur)) begin
            w_res.color = i_color_a;
        end else if (on_seg(r_s1_row, w_b_prev, w_b_cur)) begin
            w_res.color = i_color_b;
        end else begin
            w_res.color = i_color_fill;
        end
    end

    assign o_empty   = (r_res_cnt == '0);
    assign w_res_pop = i_pop && !o_empty;
    assign o_res     = r_res_q[r_res_rd];

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_res_q[r_res_wr] <= w_res;
        end
        if (!i_rst_n) begin
            r_res_wr  <= '0;
            r_res_rd  <= '0;
            r_res_cnt <= '0;
        end else begin
            if (r_s1_valid) begin
                r_res_wr <= r_res_wr + RES_AW'(1);
            end
            if (w_res_pop) begin
                r_res_rd <= r_res_rd + RES_AW'(1);
            end
            if (r_s1_valid && !w_res_pop) begin
                r_res_cnt <= r_res_cnt + RES_CW'(1);
            end else if (!r_s1_valid && w_res_pop) begin
                r_res_cnt <= r_res_cnt - RES_CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/scrolling_waveform_renderer_unit.sv
// Two-channel scrolling waveform renderer. Push a sample pair (func 0) or a
// pixel request (func 1); each pixel request yields one RGB565 pixel of a
// 320 x 240 frame in column-major order, rows inner, with frame_first and
// frame_last marking the frame corners. Samples are clamped to 32768..36863,
// scaled to rows 10..110 (channel B plus offset_b, saturating at 255) and
// stored in a 320-entry ring; the newest sample is drawn at the right edge.
// One transaction is taken per cycle on each side while the command queue is
// not full and the result queue not empty; a pixel passes through the command
// queue, the registered ring-buffer read and the color stage into the result
// queue. Until a ring entry has been written it reads as row 60 (A) and row
// 180 (B); there is no clear pass after reset. Configuration writes are always
// ready and should only be issued while the block is idle.
`default_nettype none

module scrolling_waveform_renderer_unit
    import swr_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire logic                 i_func,
    input  wire logic [RAW_W-1:0]     i_sample_a,
    input  wire logic [RAW_W-1:0]     i_sample_b,
    output logic                      empty,
    input  wire logic                 pop,
    output logic      [COLOR_W-1:0]   o_pixel_color,
    output logic                      o_frame_first,
    output logic                      o_frame_last,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [COLOR_W-1:0]   i_cfg_data
);

    logic [COLOR_W-1:0] r_color_a, r_color_b, r_color_fill;
    logic [DATA_W-1:0]  r_offset_b;

    logic w_cmd_valid, w_cmd_pop;
    t_cmd w_cmd;
    t_res w_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_a    <= RST_COLOR_A;
            r_color_b    <= RST_COLOR_B;
            r_color_fill <= RST_COLOR_FILL;
            r_offset_b   <= RST_OFFSET_B;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_COLOR_A:    r_color_a    <= i_cfg_data;
                CFG_COLOR_B:    r_color_b    <= i_cfg_data;
                CFG_COLOR_FILL: r_color_fill <= i_cfg_data;
                CFG_OFFSET_B:   r_offset_b   <= i_cfg_data[DATA_W-1:0];
            endcase
        end
    end

    swr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_func      (i_func),
        .i_sample_a  (i_sample_a),
        .i_sample_b  (i_sample_b),
        .i_offset_b  (r_offset_b),
        .o_full      (full),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    swr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (w_cmd_valid),
        .i_cmd        (w_cmd),
        .o_cmd_pop    (w_cmd_pop),
        .i_color_a    (r_color_a),
        .i_color_b    (r_color_b),
        .i_color_fill (r_color_fill),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_res        (w_res)
    );

    assign o_pixel_color = w_res.color;
    assign o_frame_first = w_res.first;
    assign o_frame_last  = w_res.last;

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not empty after reset");

    a_full_has_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> w_cmd_valid)
        else $error("command queue full but back end sees no command");

    a_corner_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> !(o_frame_first && o_frame_last))
        else $error("pixel marked both first and last of frame");

endmodule

`default_nettype wire
